>>> hdl/sdmt_pkg.sv
package sdmt_pkg;

	// One table slot as it travels along the cell row.
	typedef struct packed {
		logic signed [40:0] diagonal;
		logic [39:0]        position;
		logic [14:0]        length;
		logic [14:0]        start;
	} entry_t;

	// Result kinds, carried on the master-side tuser.
	typedef enum logic [2:0] {
		ST_EXTENDED  = 3'd0,
		ST_CONTAINED = 3'd1,
		ST_APPENDED  = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_CLEARED   = 3'd4,
		ST_DUMP      = 3'd5
	} status_t;

	// Command codes, carried on the slave-side tuser.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_DUMP   = 2'd2;

	localparam logic [6:0]  CAP_RESET = 7'd64;
	localparam logic [14:0] LEN_MAX   = 15'h7FFF;

endpackage

>>> hdl/sdmt_cell.sv
// One slot of the rotating table: on each shift it takes the entry of its neighbor.
module sdmt_cell (
	input  logic             clk,
	input  logic             shift_en,
	input  sdmt_pkg::entry_t entry_in,
	output sdmt_pkg::entry_t entry_q
);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= entry_in;
		end
	end

endmodule

>>> hdl/seed_diagonal_merge_table_unit.sv
// Insert: the scan takes the cell ring through one full revolution, then the result
// is loaded into the output register; no new command is taken before that load.
// Dump: one beat per cycle while the sink takes them, then the ring spins to complete
// its revolution. Clear: the count is zeroed and the result goes out through S_EMIT.
// Reset (arst_n low, asynchronous) empties the table and sets capacity_limit to 64;
// slot contents are not cleared, since no slot at or above the count is ever read.
module seed_diagonal_merge_table_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: capacity_limit.
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	// Seed and command stream.
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata from bit 0 up: seed_start, seed_len, ref_position, diagonal, zero fill.
	input  logic [111:0] s_axis_tdata,
	// tuser: command.
	input  logic [1:0]   s_axis_tuser,
	// Result stream.
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata from bit 0 up: entry_index, entry_start, entry_length, entry_position,
	// entry_diagonal, entry_count, zero fill.
	output logic [127:0] m_axis_tdata,
	// tuser: status.
	output logic [2:0]   m_axis_tuser,
	// tlast: last_result.
	output logic         m_axis_tlast
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [IW-1:0] STEP_LAST = IW'(TABLE_DEPTH - 1);

	// The controller walks the ring of cells. The entry in cell 0 is the slot whose
	// number equals the step counter; every shift moves each entry one cell toward
	// cell 0 and feeds the (possibly rewritten) head entry back into the far end.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT,
		S_DUMP,
		S_SPIN
	} state_t;

	state_t                state_q;
	logic [IW-1:0]         step_q;
	logic [CW-1:0]         count_q;
	logic [6:0]            cap_q;
	logic                  found_q;
	sdmt_pkg::entry_t      seed_q;
	sdmt_pkg::status_t     res_status_q;
	logic [IW-1:0]         res_index_q;
	sdmt_pkg::entry_t      res_entry_q;

	logic                  out_valid_q;
	sdmt_pkg::status_t     out_status_q;
	logic [IW-1:0]         out_index_q;
	sdmt_pkg::entry_t      out_entry_q;
	logic [CW-1:0]         out_count_q;
	logic                  out_last_q;

	sdmt_pkg::entry_t      ring [TABLE_DEPTH];
	sdmt_pkg::entry_t      head;
	sdmt_pkg::entry_t      head_new;
	sdmt_pkg::entry_t      merged;
	sdmt_pkg::entry_t      in_entry;
	logic                  shift_en;
	logic                  out_free;
	logic                  out_load;
	logic                  in_fire;
	logic [CW-1:0]         limit;
	logic                  head_zero;
	logic [15:0]           e_end;
	logic [15:0]           s_end;
	logic [15:0]           new_len;
	logic                  grow;
	logic                  hit;
	logic                  app;
	logic                  dump_last;

	// The cell row.
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		if (k == TABLE_DEPTH - 1) begin : g_tail
			sdmt_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.entry_in (head_new),
				.entry_q  (ring[k])
			);
		end else begin : g_body
			sdmt_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.entry_in (ring[k+1]),
				.entry_q  (ring[k])
			);
		end
	end

	assign head = ring[0];

	assign in_entry.start    = s_axis_tdata[14:0];
	assign in_entry.length   = s_axis_tdata[29:15];
	assign in_entry.position = s_axis_tdata[69:30];
	assign in_entry.diagonal = s_axis_tdata[110:70];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	// A new result beat enters the output register on this cycle.
	assign out_load      = out_free && ((state_q == S_EMIT) || (state_q == S_DUMP));

	// The limit in force never exceeds the table depth.
	assign limit = (cap_q > 7'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cap_q);

	// Match test on the slot that sits in cell 0. All-zero slots never match.
	always_comb begin
		head_zero = (head.start == '0) && (head.length == '0) && (head.position == '0);
		e_end     = {1'b0, head.start} + {1'b0, head.length};
		s_end     = {1'b0, seed_q.start} + {1'b0, seed_q.length};
		new_len   = s_end - {1'b0, head.start};
		grow      = s_end > e_end;
		hit       = (state_q == S_SCAN) && !found_q && (CW'(step_q) < count_q) &&
			!head_zero && (head.diagonal == seed_q.diagonal) &&
			(seed_q.start >= head.start) && ({1'b0, seed_q.start} <= e_end);
		app       = (state_q == S_SCAN) && !found_q && (CW'(step_q) == count_q) &&
			(count_q < limit);
		merged    = head;
		if (grow) begin
			merged.length = new_len[15] ? sdmt_pkg::LEN_MAX : new_len[14:0];
		end
		if (hit) begin
			head_new = merged;
		end else if (app) begin
			head_new = seed_q;
		end else begin
			head_new = head;
		end
		dump_last = (CW'(step_q) == CW'(count_q - CW'(1)));
	end

	// The ring turns every cycle of a scan or a spin, and once per beat while dumping.
	assign shift_en = (state_q == S_SCAN) || (state_q == S_SPIN) ||
		((state_q == S_DUMP) && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			count_q      <= '0;
			cap_q        <= sdmt_pkg::CAP_RESET;
			found_q      <= 1'b0;
			seed_q       <= '0;
			res_status_q <= sdmt_pkg::ST_DROPPED;
			res_index_q  <= '0;
			res_entry_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= sdmt_pkg::ST_DROPPED;
			out_index_q  <= '0;
			out_entry_q  <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						seed_q  <= in_entry;
						found_q <= 1'b0;
						step_q  <= '0;
						unique case (s_axis_tuser)
							sdmt_pkg::CMD_INSERT: begin
								state_q <= S_SCAN;
							end
							sdmt_pkg::CMD_CLEAR: begin
								count_q      <= '0;
								res_status_q <= sdmt_pkg::ST_CLEARED;
								res_index_q  <= '0;
								res_entry_q  <= '0;
								state_q      <= S_EMIT;
							end
							sdmt_pkg::CMD_DUMP: begin
								if (count_q != '0) begin
									state_q <= S_DUMP;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q      <= 1'b1;
						res_status_q <= grow ? sdmt_pkg::ST_EXTENDED : sdmt_pkg::ST_CONTAINED;
						res_index_q  <= step_q;
						res_entry_q  <= merged;
					end else if (app) begin
						found_q      <= 1'b1;
						res_status_q <= sdmt_pkg::ST_APPENDED;
						res_index_q  <= step_q;
						res_entry_q  <= seed_q;
						count_q      <= count_q + CW'(1);
					end
					if (step_q == STEP_LAST) begin
						step_q  <= '0;
						state_q <= S_EMIT;
						if (!found_q && !hit && !app) begin
							res_status_q <= sdmt_pkg::ST_DROPPED;
							res_index_q  <= '0;
							res_entry_q  <= '0;
						end
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_index_q  <= res_index_q;
						out_entry_q  <= res_entry_q;
						out_count_q  <= count_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						out_status_q <= sdmt_pkg::ST_DUMP;
						out_index_q  <= step_q;
						out_entry_q  <= head;
						out_count_q  <= count_q;
						out_last_q   <= dump_last;
						if (step_q == STEP_LAST) begin
							step_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							step_q <= step_q + IW'(1);
							if (dump_last) begin
								state_q <= S_SPIN;
							end
						end
					end
				end
				S_SPIN: begin
					if (step_q == STEP_LAST) begin
						step_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0, 7'(out_count_q), out_entry_q.diagonal,
		out_entry_q.position, out_entry_q.length, out_entry_q.start, 6'(out_index_q)};

endmodule

>>> hdl/sdmt_checker.sv
module sdmt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [2:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	// A stalled result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// A clear reports an empty table and ends its command.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == sdmt_pkg::ST_CLEARED) |->
			m_axis_tlast && (m_axis_tdata[123:117] == 7'd0) && (m_axis_tdata[116:0] == '0))
		else $error("clear beat malformed");

	// A dropped seed carries no entry.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == sdmt_pkg::ST_DROPPED) |->
			m_axis_tlast && (m_axis_tdata[116:0] == '0))
		else $error("dropped beat carries an entry");

	// Any beat that names a slot names one below the count.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != sdmt_pkg::ST_CLEARED) &&
			(m_axis_tuser != sdmt_pkg::ST_DROPPED) |->
			({1'b0, m_axis_tdata[5:0]} < m_axis_tdata[123:117]))
		else $error("slot index not below count");

	// After a clear is taken, s_axis_tready drops while its result is being produced.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == sdmt_pkg::CMD_CLEAR) |=>
			!s_axis_tready)
		else $error("input taken while a clear is pending");

endmodule

bind seed_diagonal_merge_table_unit sdmt_checker u_sdmt_checker (.*);

>>> tb/tb_seed_diagonal_merge_table_unit.sv
`timescale 1ns / 1ps

module tb_seed_diagonal_merge_table_unit;

	localparam int DEPTH = 64;
	// The longest piece of work in the block is one full turn of the cell ring.
	// After the last result has come, this many cycles cover any remaining spin.
	localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
	// Watchdog, several times the slowest correct run.
	localparam int CYCLE_LIMIT = 400000;
	// The unused command code, which the block ignores.
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// One expected result beat, field by field.
	typedef struct {
		sdmt_pkg::status_t status;
		logic [5:0]        index;
		sdmt_pkg::entry_t  entry;
		logic [6:0]        count;
		logic              is_last;
	} outcome_t;

	// Scoreboard: a predictor of the seed table and the queue of results it
	// expects to see, oldest first.
	class merge_scoreboard;
		sdmt_pkg::entry_t slots[DEPTH];
		int unsigned      held;
		int unsigned      cap_limit;
		int unsigned      errors;
		outcome_t         expected_q[$];

		function new();
			held = 0;
			cap_limit = 64;
			errors = 0;
		endfunction

		function void set_limit(logic [6:0] value);
			cap_limit = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push(sdmt_pkg::status_t st, int slot, bit with_entry, bit is_last);
			outcome_t o;
			o.status = st;
			o.index = with_entry ? 6'(slot) : '0;
			o.entry = with_entry ? slots[slot] : '0;
			o.count = 7'(held);
			o.is_last = is_last;
			expected_q.push_back(o);
		endfunction

		// Works out every result that one accepted input beat causes.
		function void note_input(logic [1:0] cmd, sdmt_pkg::entry_t seed);
			sdmt_pkg::entry_t e;
			int               span_end;
			int               new_end;
			int               grown;
			int unsigned      limit;
			limit = (cap_limit < DEPTH) ? cap_limit : DEPTH;
			case (cmd)
				sdmt_pkg::CMD_CLEAR: begin
					held = 0;
					push(sdmt_pkg::ST_CLEARED, 0, 1'b0, 1'b1);
				end
				sdmt_pkg::CMD_DUMP: begin
					for (int i = 0; i < held; i++)
						push(sdmt_pkg::ST_DUMP, i, 1'b1, i + 1 == held);
				end
				sdmt_pkg::CMD_INSERT: begin
					for (int i = 0; i < held; i++) begin
						e = slots[i];
						// Entries that are all zero never absorb anything.
						if (e.start == 0 && e.length == 0 && e.position == 0)
							continue;
						span_end = e.start + e.length;
						if (e.diagonal == seed.diagonal && seed.start >= e.start &&
								seed.start <= span_end) begin
							new_end = seed.start + seed.length;
							if (new_end > span_end) begin
								grown = new_end - e.start;
								slots[i].length = (grown > sdmt_pkg::LEN_MAX) ?
									sdmt_pkg::LEN_MAX : 15'(grown);
								push(sdmt_pkg::ST_EXTENDED, i, 1'b1, 1'b1);
							end else begin
								push(sdmt_pkg::ST_CONTAINED, i, 1'b1, 1'b1);
							end
							return;
						end
					end
					if (held < limit) begin
						slots[held] = seed;
						held++;
						push(sdmt_pkg::ST_APPENDED, held - 1, 1'b1, 1'b1);
					end else begin
						push(sdmt_pkg::ST_DROPPED, 0, 1'b0, 1'b1);
					end
				end
				default: ;  // the spare command code is ignored
			endcase
		endfunction

		function void compare_field(string what, logic [127:0] exp_v, logic [127:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v,
					act_v);
			end
		endfunction

		// Checks one accepted result beat against the oldest expectation.
		function void check_result(logic [2:0] status, logic [127:0] data, logic is_last);
			outcome_t o;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, status %0d data %0h", $time,
					status, data);
				return;
			end
			o = expected_q.pop_front();
			compare_field("status", o.status, status);
			compare_field("entry_index", o.index, data[5:0]);
			compare_field("entry_start", o.entry.start, data[20:6]);
			compare_field("entry_length", o.entry.length, data[35:21]);
			compare_field("entry_position", o.entry.position, data[75:36]);
			// The diagonal is compared as raw bits, without sign extension.
			compare_field("entry_diagonal", $unsigned(o.entry.diagonal), data[116:76]);
			compare_field("entry_count", o.count, data[123:117]);
			compare_field("last_result", o.is_last, is_last);
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [6:0]   cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// tdata from bit 0 up: seed_start, seed_len, ref_position, diagonal, zero fill.
	logic [111:0] s_axis_tdata = '0;
	// tuser: command.
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// tdata from bit 0 up: entry_index, entry_start, entry_length, entry_position,
	// entry_diagonal, entry_count, zero fill.
	logic [127:0] m_axis_tdata;
	// tuser: status.
	logic [2:0]   m_axis_tuser;
	logic         m_axis_tlast;

	// Random idling on either side; cleared for the stretch with no idling.
	bit sender_idles = 1'b1;
	bit sink_stalls = 1'b1;
	int cycle_count = 0;

	merge_scoreboard sb;

	seed_diagonal_merge_table_unit #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	// Watchdog: a run that hangs or crawls is a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// While sink_stalls is set, the sink stalls at random, roughly 18 percent of the time.
	always @(posedge clk) begin
		m_axis_tready <= sink_stalls ? ($urandom_range(0, 99) >= 18) : 1'b1;
	end

	// Inputs only move at the rising edge, so what is seen at the falling edge
	// is exactly what the next rising edge will accept. A result beat found
	// with valid and ready both high here is checked once.
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
	end

	// Presents one beat, with random gaps in front of it, and returns at the
	// rising edge that accepts it. The caller is then free to drive the next
	// beat in the same time step, so valid stays high across back-to-back beats.
	task automatic send_beat(input logic [1:0] cmd, input sdmt_pkg::entry_t seed);
		while (sender_idles && $urandom_range(0, 99) < 18) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {1'b0, seed};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		sb.note_input(cmd, seed);
	endtask

	task automatic send_seed(input logic [1:0] cmd, input logic [14:0] start,
			input logic [14:0] length, input logic [39:0] position,
			input logic [40:0] diagonal);
		sdmt_pkg::entry_t seed;
		seed.start = start;
		seed.length = length;
		seed.position = position;
		seed.diagonal = diagonal;
		send_beat(cmd, seed);
	endtask

	// Holds the sender off until every expected result has arrived. It always
	// returns at a later edge than the one that drops valid.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// The limit register is written only with the block idle: all results in,
	// then long enough for the ring to finish any revolution still under way.
	task automatic write_capacity(input logic [6:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(value);
	endtask

	// When the table holds entries, two seeds in five are aimed at what it holds, so that
	// extension, containment and saturation get exercised; some come from a small pool of
	// diagonals with short spans, and the rest are random over the full fields.
	function automatic sdmt_pkg::entry_t random_seed();
		sdmt_pkg::entry_t s;
		sdmt_pkg::entry_t e;
		logic [63:0]      w0;
		logic [63:0]      w1;
		int               r;
		int               k;
		int               hi;
		w0 = {$urandom(), $urandom()};
		w1 = {$urandom(), $urandom()};
		s.start = w0[14:0];
		s.length = w0[29:15];
		s.position = w1[39:0];
		s.diagonal = {w0[63:40], w1[56:40]};
		r = $urandom_range(0, 99);
		if (r < 40 && sb.held > 0) begin
			k = $urandom_range(0, sb.held - 1);
			e = sb.slots[k];
			s.diagonal = e.diagonal;
			hi = e.start + e.length;
			if (hi > sdmt_pkg::LEN_MAX)
				hi = sdmt_pkg::LEN_MAX;
			// Now and then a near miss just past the end of the span.
			if ($urandom_range(0, 4) == 0 && hi < sdmt_pkg::LEN_MAX)
				s.start = 15'(hi + 1);
			else
				s.start = 15'($urandom_range(e.start, hi));
			if ($urandom_range(0, 9) != 0)
				s.length = 15'($urandom_range(0, 40));
		end else if (r < 65) begin
			case ($urandom_range(0, 3))
				0: s.diagonal = '0;
				1: s.diagonal = '1;
				2: s.diagonal = {1'b1, 40'd0};
				default: s.diagonal = 41'd12345;
			endcase
			s.start = 15'($urandom_range(0, 300));
			s.length = 15'($urandom_range(0, 60));
		end
		return s;
	endfunction

	task automatic random_phase(input int n, input int clear_pct);
		int         r;
		logic [1:0] cmd;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < clear_pct)
				cmd = sdmt_pkg::CMD_CLEAR;
			else if (r < clear_pct + 6)
				cmd = sdmt_pkg::CMD_DUMP;
			else if (r < clear_pct + 8)
				cmd = CMD_SPARE;  // must be ignored
			else
				cmd = sdmt_pkg::CMD_INSERT;
			send_beat(cmd, random_seed());
		end
	endtask

	localparam logic [40:0] DIAG_MAX = {1'b0, {40{1'b1}}};
	localparam logic [40:0] DIAG_MIN = {1'b1, 40'd0};

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// A limit above the table depth acts as the full depth.
		write_capacity(7'd127);

		// Directed part. An empty dump and the spare code give no beat at all.
		send_seed(sdmt_pkg::CMD_DUMP, 15'd0, 15'd0, 40'd0, '0);
		send_seed(CMD_SPARE, '1, '1, '1, '1);
		// Two all-zero seeds: the first is held but skipped by later scans,
		// so the second is appended rather than absorbed.
		send_seed(sdmt_pkg::CMD_INSERT, 15'd0, 15'd0, 40'd0, '0);
		send_seed(sdmt_pkg::CMD_INSERT, 15'd0, 15'd0, 40'd0, '0);
		send_seed(sdmt_pkg::CMD_INSERT, sdmt_pkg::LEN_MAX, sdmt_pkg::LEN_MAX, '1, DIAG_MAX);
		send_seed(sdmt_pkg::CMD_INSERT, 15'd100, 15'd50, 40'd5, DIAG_MIN);
		// Inside the span and ending inside it: contained.
		send_seed(sdmt_pkg::CMD_INSERT, 15'd120, 15'd10, 40'd9, DIAG_MIN);
		// Starting exactly at the span end: extended.
		send_seed(sdmt_pkg::CMD_INSERT, 15'd150, 15'd5, 40'd9, DIAG_MIN);
		// Extension past the length maximum saturates.
		send_seed(sdmt_pkg::CMD_INSERT, 15'd155, sdmt_pkg::LEN_MAX, 40'd9, DIAG_MIN);
		// One short of the span start: a new entry.
		send_seed(sdmt_pkg::CMD_INSERT, 15'd99, 15'd3, 40'd1, DIAG_MIN);
		send_seed(sdmt_pkg::CMD_INSERT, sdmt_pkg::LEN_MAX, 15'd0, 40'd2, DIAG_MAX);
		send_seed(sdmt_pkg::CMD_DUMP, 15'd0, 15'd0, 40'd0, '0);
		send_seed(sdmt_pkg::CMD_CLEAR, '1, '1, '1, '1);
		send_seed(sdmt_pkg::CMD_DUMP, 15'd0, 15'd0, 40'd0, '0);

		// A limit of zero drops every new seed.
		write_capacity(7'd0);
		send_seed(sdmt_pkg::CMD_INSERT, 15'd10, 15'd20, 40'd3, 41'd7);
		// A limit of one: one append, then only absorption.
		write_capacity(7'd1);
		send_seed(sdmt_pkg::CMD_INSERT, 15'd10, 15'd20, 40'd3, 41'd7);
		send_seed(sdmt_pkg::CMD_INSERT, 15'd10, 15'd20, 40'd3, 41'd8);
		send_seed(sdmt_pkg::CMD_INSERT, 15'd30, 15'd1, 40'd4, 41'd7);
		send_seed(sdmt_pkg::CMD_DUMP, 15'd0, 15'd0, 40'd0, '0);
		send_seed(sdmt_pkg::CMD_CLEAR, 15'd0, 15'd0, 40'd0, '0);

		// Random part: a long run at full depth so the table can fill.
		write_capacity(7'd64);
		random_phase(110, 1);

		// A small limit without clears, so the table sits full.
		write_capacity(7'd5);
		random_phase(50, 0);

		// Limit lowered below the count: held entries stay in place.
		write_capacity(7'($urandom_range(1, 3)));
		random_phase(40, 0);

		// Full depth again, first with no idling on either side.
		write_capacity(7'($urandom_range(64, 127)));
		sender_idles = 1'b0;
		sink_stalls = 1'b0;
		random_phase(50, 1);
		// The sender pauses until everything in flight has come back.
		wait_drained();
		sender_idles = 1'b1;
		sink_stalls = 1'b1;
		random_phase(60, 2);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/sdmt_pkg.sv
hdl/sdmt_cell.sv
hdl/seed_diagonal_merge_table_unit.sv
hdl/sdmt_checker.sv
tb/tb_seed_diagonal_merge_table_unit.sv
